>>> hw/rtl/pal_pkg.sv
package pal_pkg;

  localparam int unsigned DefCapacity = 128;
  localparam int unsigned DataW       = 32;
  localparam int unsigned PosW        = 8;
  localparam int unsigned OutCntW     = 8;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_GET    = 2'd2;
  localparam logic [1:0] CMD_LOCATE = 2'd3;

  typedef enum logic [1:0] {
    SHIFT_HOLD,
    SHIFT_INS,
    SHIFT_DEL
  } shift_e;

  // Broadcast from the controller to every cell of the row.
  typedef struct packed {
    shift_e                  op;
    logic                    locate;
    logic [PosW-1:0]         pos;
    logic signed [DataW-1:0] val;
  } cell_ctrl_t;

endpackage

>>> hw/rtl/pal_if.sv
interface pal_in_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     cmd;
  logic [pal_pkg::PosW-1:0]       position;
  logic signed [pal_pkg::DataW-1:0] value_in;

  modport source (output valid, cmd, position, value_in, input ready);
  modport sink   (input valid, cmd, position, value_in, output ready);
endinterface

interface pal_out_if;
  logic                             valid;
  logic                             ready;
  logic                             ok;
  logic signed [pal_pkg::DataW-1:0] value_out;
  logic [pal_pkg::PosW-1:0]         found_position;
  logic [pal_pkg::OutCntW-1:0]      list_count;

  modport source (output valid, ok, value_out, found_position, list_count, input ready);
  modport sink   (input valid, ok, value_out, found_position, list_count, output ready);
endinterface

>>> hw/rtl/positional_array_list_core.sv
// An accepted item waits out the registered first-hit tree that collects the row of cells
// for get, delete and locate, then its result goes to the output register once that
// register is free; the block takes no new item until then and goes back to idle first.
// A new item is taken while the previous result waits in the output register.
// Reset (asynchronous, active low) empties the list; entry contents are not cleared.
module positional_array_list_core #(
  parameter int unsigned CAPACITY = pal_pkg::DefCapacity
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  pal_in_if.sink          in_i,
  pal_out_if.source       out_o
);
  import pal_pkg::*;

  localparam int unsigned IdxW  = $clog2(CAPACITY);
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned Last  = IdxW + 1;
  localparam int unsigned WaitW = $clog2(Last + 1);
  localparam int unsigned CmpW  = ((CntW > PosW) ? CntW : PosW) + 1;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_e;

  state_e                  state_q;
  logic [WaitW-1:0]        wait_q;
  logic [CntW-1:0]         count_q;
  logic [1:0]              cmd_q;
  logic [PosW-1:0]         pos_q;
  logic signed [DataW-1:0] val_q;

  logic                    out_valid_q;
  logic                    ok_q;
  logic signed [DataW-1:0] vout_q;
  logic [PosW-1:0]         fpos_q;
  logic [OutCntW-1:0]      lcnt_q;

  cell_ctrl_t              ctrl;
  logic signed [DataW-1:0] cell_data [CAPACITY];
  logic                    cell_hit  [CAPACITY];
  logic                    root_hit;
  logic [IdxW-1:0]         root_idx;
  logic signed [DataW-1:0] root_data;

  logic                    accept;
  logic                    finish;
  logic [CmpW-1:0]         pos_x;
  logic [CmpW-1:0]         cnt_x;
  logic                    pos_nz;
  logic                    ins_ok;
  logic                    rd_ok;
  logic                    ok_d;
  logic signed [DataW-1:0] vout_d;
  logic [PosW-1:0]         fpos_d;
  logic [CntW-1:0]         count_d;

  assign accept = in_i.valid && in_i.ready;
  assign finish = (state_q == ST_SEARCH) && (wait_q == WaitW'(Last)) &&
                  (!out_valid_q || out_o.ready);

  assign pos_x  = CmpW'(pos_q);
  assign cnt_x  = CmpW'(count_q);
  assign pos_nz = (pos_q != '0);
  assign ins_ok = (cnt_x < CmpW'(CAPACITY)) && pos_nz && (pos_x <= cnt_x + CmpW'(1));
  assign rd_ok  = pos_nz && (pos_x <= cnt_x);

  always_comb begin
    ok_d    = 1'b0;
    vout_d  = '0;
    fpos_d  = '0;
    count_d = count_q;
    unique case (cmd_q)
      CMD_INSERT: begin
        ok_d = ins_ok;
        if (ins_ok) begin
          count_d = count_q + CntW'(1);
        end
      end
      CMD_DELETE: begin
        ok_d = rd_ok;
        if (rd_ok) begin
          vout_d  = root_data;
          count_d = count_q - CntW'(1);
        end
      end
      CMD_GET: begin
        ok_d = rd_ok;
        if (rd_ok) begin
          vout_d = root_data;
        end
      end
      CMD_LOCATE: begin
        ok_d = root_hit;
        if (root_hit) begin
          fpos_d = PosW'((IdxW + 1)'(root_idx) + (IdxW + 1)'(1));
        end
      end
    endcase
  end

  // The row only shifts at the edge that completes a successful insert or delete.
  always_comb begin
    ctrl.op     = SHIFT_HOLD;
    ctrl.locate = (cmd_q == CMD_LOCATE);
    ctrl.pos    = pos_q;
    ctrl.val    = val_q;
    if (finish && cmd_q == CMD_INSERT && ins_ok) begin
      ctrl.op = SHIFT_INS;
    end else if (finish && cmd_q == CMD_DELETE && rd_ok) begin
      ctrl.op = SHIFT_DEL;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DataW-1:0] left;
    logic signed [DataW-1:0] right;
    if (i == 0) begin : g_first
      assign left = val_q;
    end else begin : g_mid
      assign left = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner
      assign right = cell_data[i+1];
    end
    pal_cell #(
      .Index  (i),
      .CountW (CntW)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .count_i (count_q),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[i]),
      .hit_o   (cell_hit[i])
    );
  end

  pal_tree #(
    .Leaves (CAPACITY),
    .IdxW   (IdxW)
  ) u_tree (
    .clk_i  (clk_i),
    .hit_i  (cell_hit),
    .data_i (cell_data),
    .hit_o  (root_hit),
    .idx_o  (root_idx),
    .data_o (root_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wait_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_SEARCH;
            wait_q  <= '0;
          end
        end
        ST_SEARCH: begin
          if (finish) begin
            state_q <= ST_IDLE;
            count_q <= count_d;
          end else if (wait_q != WaitW'(Last)) begin
            wait_q <= wait_q + WaitW'(1);
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= in_i.cmd;
      pos_q <= in_i.position;
      val_q <= in_i.value_in;
    end
    if (finish) begin
      ok_q   <= ok_d;
      vout_q <= vout_d;
      fpos_q <= fpos_d;
      lcnt_q <= OutCntW'(count_d);
    end
  end

  assign in_i.ready           = (state_q == ST_IDLE);
  assign out_o.valid          = out_valid_q;
  assign out_o.ok             = ok_q;
  assign out_o.value_out      = vout_q;
  assign out_o.found_position = fpos_q;
  assign out_o.list_count     = lcnt_q;

`ifndef SYNTH
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(count_q) <= CAPACITY)
    else $error("entry count exceeds capacity");

  a_count_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH && !finish) |=> $stable(count_q))
    else $error("entry count changed during a search");

  a_finish_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> out_valid_q)
    else $error("finished item did not reach the output register");

  a_found_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (fpos_q == '0 || ok_q))
    else $error("found position reported without success");
`endif

endmodule

>>> hw/rtl/pal_cell.sv
module pal_cell #(
  parameter int unsigned Index  = 0,
  parameter int unsigned CountW = 8
) (
  input  logic                             clk_i,
  input  pal_pkg::cell_ctrl_t              ctrl_i,
  input  logic [CountW-1:0]                count_i,
  input  logic signed [pal_pkg::DataW-1:0] left_i,
  input  logic signed [pal_pkg::DataW-1:0] right_i,
  output logic signed [pal_pkg::DataW-1:0] data_o,
  output logic                             hit_o
);
  import pal_pkg::*;

  logic signed [DataW-1:0] data_q;
  logic signed [DataW-1:0] data_d;
  logic                    at_pos;
  logic                    past_pos;
  logic                    occupied;

  // Positions are 1-based, so this cell sits at position Index + 1.
  assign at_pos   = (int'(ctrl_i.pos) == Index + 1);
  assign past_pos = (int'(ctrl_i.pos) < Index + 1);
  assign occupied = (int'(count_i) > Index);

  always_comb begin
    data_d = data_q;
    unique case (ctrl_i.op)
      SHIFT_HOLD: data_d = data_q;
      SHIFT_INS: begin
        if (at_pos) begin
          data_d = ctrl_i.val;
        end else if (past_pos) begin
          data_d = left_i;
        end
      end
      SHIFT_DEL: begin
        if (at_pos || past_pos) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign hit_o  = ctrl_i.locate ? (occupied && (data_q == ctrl_i.val)) : at_pos;
  assign data_o = data_q;

endmodule

>>> hw/rtl/pal_tree.sv
module pal_tree #(
  parameter int unsigned Leaves = pal_pkg::DefCapacity,
  parameter int unsigned IdxW   = $clog2(Leaves)
) (
  input  logic                             clk_i,
  input  logic                             hit_i  [Leaves],
  input  logic signed [pal_pkg::DataW-1:0] data_i [Leaves],
  output logic                             hit_o,
  output logic [IdxW-1:0]                  idx_o,
  output logic signed [pal_pkg::DataW-1:0] data_o
);
  import pal_pkg::*;

  localparam int unsigned NumLeaf = 1 << IdxW;

  typedef struct packed {
    logic                    hit;
    logic [IdxW-1:0]         idx;
    logic signed [DataW-1:0] data;
  } node_t;

  // Heap layout: node k has children 2k and 2k+1, leaves start at NumLeaf.
  node_t node_q [1:2*NumLeaf-1];

  for (genvar j = 0; j < NumLeaf; j++) begin : g_leaf
    if (j < Leaves) begin : g_real
      always_ff @(posedge clk_i) begin
        node_q[NumLeaf+j] <= '{hit: hit_i[j], idx: IdxW'(j), data: data_i[j]};
      end
    end else begin : g_pad
      always_ff @(posedge clk_i) begin
        node_q[NumLeaf+j] <= '0;
      end
    end
  end

  // The lower position wins, so the root holds the first hit.
  for (genvar k = 1; k < NumLeaf; k++) begin : g_node
    always_ff @(posedge clk_i) begin
      node_q[k] <= node_q[2*k].hit ? node_q[2*k] : node_q[2*k+1];
    end
  end

  assign hit_o  = node_q[1].hit;
  assign idx_o  = node_q[1].idx;
  assign data_o = node_q[1].data;

endmodule

>>> dv/positional_array_list_core_test.sv
module positional_array_list_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pal_pkg::*;

  localparam int unsigned CAPACITY = DefCapacity;
  localparam int LatencyCycles = $clog2(CAPACITY) + 2;

  typedef struct packed {
    logic                    ok;
    logic signed [DataW-1:0] value;
    logic [PosW-1:0]         found;
    logic [OutCntW-1:0]      count;
  } list_result_t;

  typedef struct packed {
    logic [1:0]              cmd;
    logic [PosW-1:0]         pos;
    logic signed [DataW-1:0] val;
    logic                    known;
    list_result_t            want;
  } stim_row_t;

  typedef enum int {
    MIX_FILL,
    MIX_BALANCED,
    MIX_DRAIN
  } traffic_mix_e;

  // Rows with known cleared are checked against the list predictor only.
  localparam stim_row_t DirectedRows [24] = '{
    '{CMD_GET,    8'd1,   32'h1234_5678, 1'b1, '{1'b0, 32'h0,         8'd0, 8'd0}},
    '{CMD_DELETE, 8'd1,   32'h0,         1'b1, '{1'b0, 32'h0,         8'd0, 8'd0}},
    '{CMD_LOCATE, 8'd1,   32'h0,         1'b1, '{1'b0, 32'h0,         8'd0, 8'd0}},
    '{CMD_INSERT, 8'd0,   32'h5,         1'b1, '{1'b0, 32'h0,         8'd0, 8'd0}},
    '{CMD_INSERT, 8'd2,   32'h5,         1'b1, '{1'b0, 32'h0,         8'd0, 8'd0}},
    '{CMD_INSERT, 8'd1,   32'h7fff_ffff, 1'b1, '{1'b1, 32'h0,         8'd0, 8'd1}},
    '{CMD_INSERT, 8'd1,   32'h8000_0000, 1'b1, '{1'b1, 32'h0,         8'd0, 8'd2}},
    '{CMD_INSERT, 8'd3,   32'hffff_ffff, 1'b1, '{1'b1, 32'h0,         8'd0, 8'd3}},
    '{CMD_INSERT, 8'd5,   32'h1,         1'b1, '{1'b0, 32'h0,         8'd0, 8'd3}},
    '{CMD_GET,    8'd1,   32'hffff_ffff, 1'b1, '{1'b1, 32'h8000_0000, 8'd0, 8'd3}},
    '{CMD_GET,    8'd3,   32'h0,         1'b1, '{1'b1, 32'hffff_ffff, 8'd0, 8'd3}},
    '{CMD_GET,    8'd4,   32'h0,         1'b1, '{1'b0, 32'h0,         8'd0, 8'd3}},
    '{CMD_GET,    8'd255, 32'h0,         1'b1, '{1'b0, 32'h0,         8'd0, 8'd3}},
    '{CMD_LOCATE, 8'd0,   32'h7fff_ffff, 1'b1, '{1'b1, 32'h0,         8'd2, 8'd3}},
    '{CMD_INSERT, 8'd2,   32'h0,         1'b1, '{1'b1, 32'h0,         8'd0, 8'd4}},
    '{CMD_INSERT, 8'd2,   32'h0,         1'b1, '{1'b1, 32'h0,         8'd0, 8'd5}},
    '{CMD_LOCATE, 8'd200, 32'h0,         1'b0, '0},
    '{CMD_LOCATE, 8'd1,   32'h5,         1'b1, '{1'b0, 32'h0,         8'd0, 8'd5}},
    '{CMD_DELETE, 8'd0,   32'h0,         1'b1, '{1'b0, 32'h0,         8'd0, 8'd5}},
    '{CMD_DELETE, 8'd6,   32'h0,         1'b1, '{1'b0, 32'h0,         8'd0, 8'd5}},
    '{CMD_DELETE, 8'd5,   32'h0,         1'b1, '{1'b1, 32'hffff_ffff, 8'd0, 8'd4}},
    '{CMD_DELETE, 8'd1,   32'hffff_ffff, 1'b1, '{1'b1, 32'h8000_0000, 8'd0, 8'd3}},
    '{CMD_GET,    8'd3,   32'h0,         1'b0, '0},
    '{CMD_GET,    8'd128, 32'h0,         1'b1, '{1'b0, 32'h0,         8'd0, 8'd3}}
  };

  localparam int NumPhases = 7;
  localparam traffic_mix_e PhaseMix [NumPhases] = '{
    MIX_FILL, MIX_BALANCED, MIX_DRAIN, MIX_FILL, MIX_BALANCED, MIX_DRAIN, MIX_BALANCED
  };
  localparam int PhaseItems [NumPhases] = '{260, 200, 260, 240, 130, 120, 40};

  logic clk_i;
  logic rst_ni;

  pal_in_if  in_if ();
  pal_out_if out_if ();

  positional_array_list_core #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  logic signed [DataW-1:0] shadow_list [CAPACITY];
  int                      shadow_len;
  list_result_t            pending_results [$];
  int                      fail_count;
  logic                    steady_source;
  logic                    steady_sink;
  int                      hold_tickets;

  initial begin
    clk_i = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  // Applies one command to the shadow list and returns the result it must give.
  function automatic list_result_t run_list_command(input logic [1:0] c,
                                                    input logic [PosW-1:0] p,
                                                    input logic signed [DataW-1:0] v);
    list_result_t r;
    int k;
    r = '0;
    case (c)
      CMD_INSERT: begin
        if (shadow_len < CAPACITY && p >= 1 && p <= shadow_len + 1) begin
          for (k = shadow_len; k >= p; k--) shadow_list[k] = shadow_list[k-1];
          shadow_list[p-1] = v;
          shadow_len++;
          r.ok = 1'b1;
        end
      end
      CMD_DELETE: begin
        if (p >= 1 && p <= shadow_len) begin
          r.value = shadow_list[p-1];
          for (k = p; k < shadow_len; k++) shadow_list[k-1] = shadow_list[k];
          shadow_len--;
          r.ok = 1'b1;
        end
      end
      CMD_GET: begin
        if (p >= 1 && p <= shadow_len) begin
          r.value = shadow_list[p-1];
          r.ok = 1'b1;
        end
      end
      default: begin
        for (k = 0; k < shadow_len; k++) begin
          if (shadow_list[k] == v) begin
            r.found = PosW'(k + 1);
            r.ok = 1'b1;
            break;
          end
        end
      end
    endcase
    r.count = OutCntW'(shadow_len);
    return r;
  endfunction

  function automatic int pick_gap(input logic steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [1:0] pick_command(input traffic_mix_e mix);
    int r;
    int ins_pct;
    int del_pct;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:     begin ins_pct = 70; del_pct = 10; end
      MIX_DRAIN:    begin ins_pct = 10; del_pct = 60; end
      default:      begin ins_pct = 30; del_pct = 25; end
    endcase
    if (r < ins_pct) return CMD_INSERT;
    if (r < ins_pct + del_pct) return CMD_DELETE;
    if (r < ins_pct + del_pct + (100 - ins_pct - del_pct) / 2) return CMD_GET;
    return CMD_LOCATE;
  endfunction

  // Mostly legal positions with the ends favored; the rest is out of range or noise.
  function automatic logic [PosW-1:0] pick_position(input logic [1:0] c);
    int r;
    int hi;
    hi = (c == CMD_INSERT) ? shadow_len + 1 : shadow_len;
    r = $urandom_range(0, 99);
    if (hi == 0 || r < 10) return PosW'($urandom_range(0, 255));
    if (r < 20) return PosW'(1);
    if (r < 30) return PosW'(hi);
    if (r < 35) return PosW'(hi + 1);
    return PosW'($urandom_range(1, hi));
  endfunction

  // Small values give duplicates, so locate has to pick the first match.
  function automatic logic signed [DataW-1:0] pick_value(input logic [1:0] c);
    int r;
    r = $urandom_range(0, 99);
    if (c == CMD_LOCATE && shadow_len > 0 && r < 60)
      return shadow_list[$urandom_range(0, shadow_len - 1)];
    if (r < 70) return $urandom;
    return int'($urandom_range(0, 15)) - 8;
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_command(input logic [1:0] c, input logic [PosW-1:0] p,
                              input logic signed [DataW-1:0] v, input logic known,
                              input list_result_t want);
    int gap;
    list_result_t predicted;
    gap = pick_gap(steady_source);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.cmd      <= c;
    in_if.position <= p;
    in_if.value_in <= v;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    predicted = run_list_command(c, p, v);
    pending_results.push_back(known ? want : predicted);
    @(negedge clk_i);
  endtask

  task automatic wait_for_results;
    in_if.valid <= 1'b0;
    do @(negedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  initial begin : result_sink
    int stall_left;
    int hold_left;
    int tickets_seen;
    stall_left   = 0;
    hold_left    = 0;
    tickets_seen = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_tickets != tickets_seen) begin
        tickets_seen = hold_tickets;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        stall_left = pick_gap(steady_sink);
        out_if.ready <= (stall_left == 0);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    list_result_t want;
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result item with no command outstanding");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("ok", 32'(want.ok), 32'(out_if.ok));
        check_field("value_out", want.value, out_if.value_out);
        check_field("found_position", 32'(want.found), 32'(out_if.found_position));
        check_field("list_count", 32'(want.count), 32'(out_if.list_count));
      end
    end
  end

  initial begin : stimulus
    int i;
    int ph;
    logic [1:0] c;
    fail_count     = 0;
    shadow_len     = 0;
    steady_source  = 1'b0;
    steady_sink    = 1'b0;
    hold_tickets   = 0;
    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.cmd      = CMD_INSERT;
    in_if.position = '0;
    in_if.value_in = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (i = 0; i < $size(DirectedRows); i++) begin
      send_command(DirectedRows[i].cmd, DirectedRows[i].pos, DirectedRows[i].val,
                   DirectedRows[i].known, DirectedRows[i].want);
    end

    for (ph = 0; ph < NumPhases; ph++) begin
      wait_for_results();
      // The balanced phases run without gaps; the first one also starts with
      // a long receiver hold-off so the block backs up into its input.
      steady_source = (PhaseMix[ph] == MIX_BALANCED);
      steady_sink   = (PhaseMix[ph] == MIX_BALANCED);
      if (ph == 1) hold_tickets++;
      for (i = 0; i < PhaseItems[ph]; i++) begin
        c = pick_command(PhaseMix[ph]);
        send_command(c, pick_position(c), pick_value(c), 1'b0, '0);
      end
    end

    wait_for_results();
    repeat (2 * LatencyCycles) @(negedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0)
      $display("positional_array_list_core test passed");
    else
      $display("positional_array_list_core test failed");
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("positional_array_list_core test failed");
    $finish;
  end

endmodule

>>> positional_array_list_core.f
hw/rtl/pal_pkg.sv
hw/rtl/pal_if.sv
hw/rtl/pal_cell.sv
hw/rtl/pal_tree.sv
hw/rtl/positional_array_list_core.sv
dv/positional_array_list_core_test.sv
